// ----- hw/rtl/psf_pkg.sv -----
package psf_pkg;

   localparam int PATTERN_MAX_DEFAULT    = 16;
   localparam int POSITION_WIDTH_DEFAULT = 16;

   // The pattern registers always hold sixteen bytes.
   localparam int PATTERN_BYTES = 16;
   localparam int PATTERN_IDX_W = 4;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int PLEN_W      = 5;
   localparam int CUT_W       = 5;
   localparam int SPLIT_W     = 16;

   localparam logic [SPLIT_W-1:0] SPLIT_MAX  = 16'hFFFF;
   localparam logic [PLEN_W-1:0]  PLEN_RESET = 5'd1;
   localparam logic [CUT_W-1:0]   CUT_RESET  = 5'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUT_DISTANCE = 2'd3;

   // Control of the byte held in the history stage.
   typedef struct packed {
      logic valid;
      logic last;
   } psf_stage_type;

   // Outcome of the comparison for one item.
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic               last;
      logic [SPLIT_W-1:0] split;
      logic [SPLIT_W-1:0] total;
   } psf_result_type;

endpackage

// ----- hw/rtl/psf_hist.sv -----
module psf_hist import psf_pkg::*; #(
   parameter int PATTERN_MAX    = PATTERN_MAX_DEFAULT,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_end_of_buffer,
   input  logic                               advance,
   output psf_stage_type                      stage,
   output logic [PATTERN_MAX-1:0][7:0]        history,
   output logic [POSITION_WIDTH-1:0]          count
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   logic                               accept;
   logic [POSITION_WIDTH-1:0]          count_next;
   psf_stage_type                      stage_ff, stage_in;
   logic [PATTERN_MAX-1:0][7:0]        history_ff, history_in;
   logic [POSITION_WIDTH-1:0]          count_ff, count_in;
   logic [POSITION_WIDTH-1:0]          position_ff, position_in;

   assign req_ready = !stage_ff.valid || advance;
   assign accept    = req_valid && req_ready;

   // The byte count stops at its maximum.
   assign count_next = (position_ff == POS_MAX) ? position_ff
                                                 : position_ff + POSITION_WIDTH'(1);

   always_comb begin
      stage_in    = stage_ff;
      history_in  = history_ff;
      count_in    = count_ff;
      position_in = position_ff;
      if (accept) begin
         stage_in.valid = 1'b1;
         stage_in.last  = req_end_of_buffer;
         history_in[0]  = req_data_byte;
         for (int k = 1; k < PATTERN_MAX; k++) begin
            history_in[k] = history_ff[k-1];
         end
         count_in    = count_next;
         position_in = req_end_of_buffer ? '0 : count_next;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= '0;
         history_ff  <= '0;
         position_ff <= '0;
      end else begin
         stage_ff    <= stage_in;
         history_ff  <= history_in;
         position_ff <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign stage   = stage_ff;
   assign history = history_ff;
   assign count   = count_ff;

endmodule

// ----- hw/rtl/psf_match.sv -----
module psf_match import psf_pkg::*; #(
   parameter int PATTERN_MAX    = PATTERN_MAX_DEFAULT,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  psf_stage_type                      stage,
   input  logic [PATTERN_MAX-1:0][7:0]        history,
   input  logic [POSITION_WIDTH-1:0]          count,
   input  logic [PATTERN_BYTES-1:0][7:0]      pattern,
   input  logic [PLEN_W-1:0]                  pattern_length,
   input  logic [CUT_W-1:0]                   cut_distance,
   output psf_result_type                     result
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int SUM_W = (POSITION_WIDTH + 1 > SPLIT_W + 1) ? POSITION_WIDTH + 1
                                                             : SPLIT_W + 1;

   logic [LEN_W-1:0]         len_eff;
   logic [PLEN_W-1:0]        pidx [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]   byte_ok;
   logic                     hit;
   logic [SUM_W-1:0]         split_sum;
   logic [SUM_W-1:0]         total_wide;

   always_comb begin
      if (pattern_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (pattern_length > PLEN_W'(PATTERN_MAX)) begin
         len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         len_eff = LEN_W'(pattern_length);
      end
   end

   // The newest byte meets the last pattern byte, the oldest in use meets the first.
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         pidx[k]    = PLEN_W'(len_eff) - PLEN_W'(1) - PLEN_W'(k);
         byte_ok[k] = (PLEN_W'(k) >= PLEN_W'(len_eff)) ||
                      (history[k] == pattern[pidx[k][PATTERN_IDX_W-1:0]]);
      end
   end

   assign hit = (&byte_ok) && (count >= POSITION_WIDTH'(len_eff));

   assign split_sum  = SUM_W'(count) - SUM_W'(len_eff) + SUM_W'(cut_distance);
   assign total_wide = SUM_W'(count);

   always_comb begin
      result.valid = stage.valid;
      result.hit   = hit;
      result.last  = stage.last;
      result.split = (split_sum > SUM_W'(SPLIT_MAX)) ? SPLIT_MAX : split_sum[SPLIT_W-1:0];
      result.total = (total_wide > SUM_W'(SPLIT_MAX)) ? SPLIT_MAX : total_wide[SPLIT_W-1:0];
   end

endmodule

// ----- hw/rtl/psf_rsp.sv -----
module psf_rsp import psf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  psf_result_type       result,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SPLIT_W-1:0]   rsp_split_position,
   output logic                 rsp_final_split,
   output logic                 rsp_last_of_run
);

   logic                 slot_free;
   logic                 load;
   logic                 valid_ff, valid_in;
   logic                 hit_pend_ff, hit_pend_in;
   logic                 last_ff, last_in;
   logic [SPLIT_W-1:0]   split_ff, split_in;
   logic [SPLIT_W-1:0]   total_ff, total_in;

   // The register frees up when its last pending result is taken.
   assign slot_free = !valid_ff || (rsp_ready && !(hit_pend_ff && last_ff));
   assign load      = result.valid && (result.hit || result.last) && slot_free;
   assign take      = result.valid && (!(result.hit || result.last) || slot_free);

   always_comb begin
      valid_in    = valid_ff;
      hit_pend_in = hit_pend_ff;
      last_in     = last_ff;
      split_in    = split_ff;
      total_in    = total_ff;
      if (load) begin
         valid_in    = 1'b1;
         hit_pend_in = result.hit;
         last_in     = result.last;
         split_in    = result.split;
         total_in    = result.total;
      end else if (valid_ff && rsp_ready) begin
         if (hit_pend_ff && last_ff) begin
            hit_pend_in = 1'b0;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         hit_pend_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         hit_pend_ff <= hit_pend_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      split_ff <= split_in;
      total_ff <= total_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_split_position = hit_pend_ff ? split_ff : total_ff;
   assign rsp_final_split    = !hit_pend_ff;
   assign rsp_last_of_run    = !(hit_pend_ff && last_ff);

endmodule

// ----- hw/rtl/pattern_split_point_finder.sv -----
// Takes one buffer byte per item and reports a split point for every occurrence of the
// configured pattern (overlapping ones included) at match start plus cut_distance, and on
// the byte marked end_of_buffer a closing split at the buffer length, after which the byte
// position restarts at zero. An item is taken in every cycle unless the output register
// is stalled; the byte is registered in the history stage and its result in the output
// register. A byte with both a match split and the closing split occupies the single
// output register until both are taken and stalls the input. Split values saturate at
// 65535 and the byte count at the top of its POSITION_WIDTH range. The user must write
// the configuration registers only while the block is idle; the block does not enforce it.
module pattern_split_point_finder import psf_pkg::*; #(
   parameter int PATTERN_MAX    = PATTERN_MAX_DEFAULT,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_end_of_buffer,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [SPLIT_W-1:0]       rsp_split_position,
   output logic                     rsp_final_split,
   output logic                     rsp_last_of_run
);

   logic [CSR_DATA_W-1:0]           pattern_low_ff, pattern_low_in;
   logic [CSR_DATA_W-1:0]           pattern_high_ff, pattern_high_in;
   logic [PLEN_W-1:0]               pattern_length_ff, pattern_length_in;
   logic [CUT_W-1:0]                cut_distance_ff, cut_distance_in;
   logic [PATTERN_BYTES-1:0][7:0]   pattern;

   psf_stage_type                   stage;
   logic [PATTERN_MAX-1:0][7:0]     history;
   logic [POSITION_WIDTH-1:0]       count;
   psf_result_type                  result;
   logic                            take;

   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      pattern_length_in = pattern_length_ff;
      cut_distance_in   = cut_distance_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_in    = csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_in   = csr_write_data;
            CSR_PATTERN_LEN:  pattern_length_in = csr_write_data[PLEN_W-1:0];
            CSR_CUT_DISTANCE: cut_distance_in   = csr_write_data[CUT_W-1:0];
            default:          pattern_low_in    = pattern_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= PLEN_RESET;
         cut_distance_ff   <= CUT_RESET;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         pattern_length_ff <= pattern_length_in;
         cut_distance_ff   <= cut_distance_in;
      end
   end

   assign pattern = {pattern_high_ff, pattern_low_ff};

   psf_hist #(
      .PATTERN_MAX    (PATTERN_MAX),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_hist (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .advance           (take),
      .stage             (stage),
      .history           (history),
      .count             (count)
   );

   psf_match #(
      .PATTERN_MAX    (PATTERN_MAX),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_match (
      .stage          (stage),
      .history        (history),
      .count          (count),
      .pattern        (pattern),
      .pattern_length (pattern_length_ff),
      .cut_distance   (cut_distance_ff),
      .result         (result)
   );

   psf_rsp u_rsp (
      .clock              (clock),
      .reset              (reset),
      .result             (result),
      .take               (take),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_split_position (rsp_split_position),
      .rsp_final_split    (rsp_final_split),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// ----- hw/rtl/psf_checker.sv -----
module psf_checker import psf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [SPLIT_W-1:0]       rsp_split_position,
   input  logic                     rsp_final_split,
   input  logic                     rsp_last_of_run
);

   // A closing split always ends the run of results for its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_split |-> rsp_last_of_run)
      else $error("closing split not marked as last of run");

   // A match split that is not last is followed at once by the closing split.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_final_split)
      else $error("second result of a run missing");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_split_position) &&
                                  $stable(rsp_final_split) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // The input is held back only while a result waits at the output.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // Nothing is shown right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pattern_split_point_finder psf_checker u_psf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_split_position (rsp_split_position),
   .rsp_final_split    (rsp_final_split),
   .rsp_last_of_run    (rsp_last_of_run)
);

// ----- dv/pattern_split_point_finder_checker.sv -----
`timescale 1ns / 100ps

module pattern_split_point_finder_checker import psf_pkg::*; #(
   parameter int PATTERN_MAX    = PATTERN_MAX_DEFAULT,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_end_of_buffer,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [SPLIT_W-1:0]     rsp_split_position,
   input  logic                   rsp_final_split,
   input  logic                   rsp_last_of_run,
   output int                     error_count,
   output int                     outstanding,
   output int                     splits_checked
);

   typedef struct packed {
      logic [SPLIT_W-1:0] split_position;
      logic               final_split;
      logic               last_of_run;
   } split_entry_type;

   localparam longint POSITION_TOP = (longint'(1) << POSITION_WIDTH) - 1;

   split_entry_type           expected_splits[$];
   logic [CSR_DATA_W-1:0]     pattern_low;
   logic [CSR_DATA_W-1:0]     pattern_high;
   logic [PLEN_W-1:0]         pattern_len;
   logic [CUT_W-1:0]          cut_offset;
   logic [7:0]                recent_bytes [PATTERN_MAX];
   logic [POSITION_WIDTH-1:0] bytes_seen;

   initial begin
      error_count    = 0;
      outstanding    = 0;
      splits_checked = 0;
   end

   // Works out the splits that one accepted byte causes and queues them in order.
   task automatic predict_splits(input logic [7:0] data, input logic closing);
      int                         len;
      longint                     count;
      longint                     split;
      logic                       hit;
      split_entry_type            entry;
      logic [8*PATTERN_BYTES-1:0] pattern;
      pattern = {pattern_high, pattern_low};
      len = int'(pattern_len);
      if (len == 0) len = 1;
      if (len > PATTERN_MAX) len = PATTERN_MAX;
      for (int k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = data;
      count = longint'(bytes_seen) + 1;
      if (count > POSITION_TOP) count = POSITION_TOP;
      // The newest byte has to line up with the last pattern byte.
      hit = (count >= len);
      for (int k = 0; k < len; k++) begin
         if (recent_bytes[k] != pattern[8*(len-1-k) +: 8]) hit = 1'b0;
      end
      if (hit) begin
         split = count - len + longint'(cut_offset);
         entry.split_position = (split > longint'(SPLIT_MAX)) ? SPLIT_MAX : split[SPLIT_W-1:0];
         entry.final_split    = 1'b0;
         entry.last_of_run    = !closing;
         expected_splits.insert(expected_splits.size(), entry);
      end
      if (closing) begin
         entry.split_position = (count > longint'(SPLIT_MAX)) ? SPLIT_MAX : count[SPLIT_W-1:0];
         entry.final_split    = 1'b1;
         entry.last_of_run    = 1'b1;
         expected_splits.insert(expected_splits.size(), entry);
         bytes_seen = '0;
      end else begin
         bytes_seen = count[POSITION_WIDTH-1:0];
      end
   endtask

   task automatic compare_split();
      split_entry_type want;
      splits_checked++;
      if (expected_splits.size() == 0) begin
         $display("%0t: unexpected split item: split_position %0d final_split %0b last_of_run %0b",
                  $time, rsp_split_position, rsp_final_split, rsp_last_of_run);
         error_count++;
      end else begin
         want = expected_splits.pop_front();
         if (rsp_split_position !== want.split_position) begin
            $display("%0t: split_position expected %0d actual %0d",
                     $time, want.split_position, rsp_split_position);
            error_count++;
         end
         if (rsp_final_split !== want.final_split) begin
            $display("%0t: final_split expected %0b actual %0b",
                     $time, want.final_split, rsp_final_split);
            error_count++;
         end
         if (rsp_last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want.last_of_run, rsp_last_of_run);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_splits.delete();
         pattern_low  = '0;
         pattern_high = '0;
         pattern_len  = PLEN_RESET;
         cut_offset   = CUT_RESET;
         for (int k = 0; k < PATTERN_MAX; k++) recent_bytes[k] = 8'h00;
         bytes_seen = '0;
      end else begin
         if (rsp_valid && rsp_ready) compare_split();
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PATTERN_LOW: pattern_low = csr_write_data;
               CSR_PATTERN_HIGH: pattern_high = csr_write_data;
               CSR_PATTERN_LEN: pattern_len = csr_write_data[PLEN_W-1:0];
               CSR_CUT_DISTANCE: cut_offset = csr_write_data[CUT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_splits(req_data_byte, req_end_of_buffer);
      end
      outstanding = expected_splits.size();
   end

endmodule

// ----- dv/pattern_split_point_finder_tb.sv -----
`timescale 1ns / 100ps

module pattern_split_point_finder_tb import psf_pkg::*;;

   localparam int     QUIET_LIMIT   = 2000;
   localparam int     SETTLE_CYCLES = 10;
   localparam int     PHASE_ITEMS   = 45;

   logic                   clock;
   logic                   reset              = 1'b1;
   logic                   csr_write_enable   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0]  csr_write_data     = '0;
   logic                   req_valid          = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte      = 8'h00;
   logic                   req_end_of_buffer  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready          = 1'b0;
   logic [SPLIT_W-1:0]     rsp_split_position;
   logic                   rsp_final_split;
   logic                   rsp_last_of_run;

   int error_count;
   int outstanding;
   int splits_checked;

   int                         items_sent    = 0;
   int                         settings_run  = 0;
   int                         burst_left    = 0;
   int                         quiet_cycles  = 0;
   logic [8*PATTERN_BYTES-1:0] cur_pattern   = '0;
   int                         cur_len       = 1;

   int          stall_left = 0;
   logic [1:0]  stall_mode = 2'd0;
   logic [31:0] stall_bits = 32'h1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   pattern_split_point_finder DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_split_position (rsp_split_position),
      .rsp_final_split    (rsp_final_split),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   pattern_split_point_finder_checker split_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_split_position (rsp_split_position),
      .rsp_final_split    (rsp_final_split),
      .rsp_last_of_run    (rsp_last_of_run),
      .error_count        (error_count),
      .outstanding        (outstanding),
      .splits_checked     (splits_checked)
   );

   // The receiver switches now and then between always ready, a repeating
   // stall pattern and plain random stalls. Each pattern has at least one ready bit.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         stall_bits <= $urandom | 32'h1;
         stall_left <= $urandom_range(16, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= stall_bits[stall_left % 8];
         2'd2: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= stall_bits[stall_left % 32];
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] pattern_at(input int idx);
      return cur_pattern[8*idx +: 8];
   endfunction

   // Eight bytes drawn from two letters, so that matches tend to overlap.
   function automatic logic [63:0] two_letter_word();
      logic [63:0] word;
      for (int i = 0; i < 8; i++) word[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
      return word;
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic closing);
      logic taken;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_end_of_buffer <= closing;
      // Ready is sampled on the falling edge so the decision never races the rising edge.
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   // Stops sending until every expected split has come, then lets the pipeline empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [63:0] low, input logic [63:0] high,
                                input logic [4:0] plen, input logic [4:0] cut);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PATTERN_LOW;
      csr_write_data   <= low;
      @(posedge clock);
      csr_index        <= CSR_PATTERN_HIGH;
      csr_write_data   <= high;
      @(posedge clock);
      csr_index        <= CSR_PATTERN_LEN;
      csr_write_data   <= 64'(plen);
      @(posedge clock);
      csr_index        <= CSR_CUT_DISTANCE;
      csr_write_data   <= 64'(cut);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_pattern = {high, low};
      cur_len = (plen == 0) ? 1 : (plen > PATTERN_BYTES) ? PATTERN_BYTES : int'(plen);
      settings_run++;
   endtask

   // Most buffers are chains of pattern copies, some restarting part way through
   // and some with a damaged byte; the rest are noise.
   task automatic send_random_buffer();
      int         buffer_len;
      int         idx;
      logic       well_formed;
      logic [7:0] data;
      buffer_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80)
                                               : $urandom_range(1, cur_len + 10);
      well_formed = ($urandom_range(0, 3) != 0);
      idx = 0;
      for (int i = 0; i < buffer_len; i++) begin
         if (well_formed) begin
            data = pattern_at(idx);
            idx++;
            if (idx >= cur_len) idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cur_len - 1) : 0;
            if ($urandom_range(0, 19) == 0) data = data ^ (8'h01 << $urandom_range(0, 7));
         end else begin
            data = $urandom_range(0, 1) ? pattern_at($urandom_range(0, cur_len - 1))
                                        : 8'($urandom);
         end
         send_byte(data, i == buffer_len - 1);
      end
   endtask

   task automatic run_phase(input logic [63:0] low, input logic [63:0] high,
                            input logic [4:0] plen, input logic [4:0] cut, input int count);
      int   first;
      logic paused;
      wait_idle();
      apply_setting(low, high, plen, cut);
      first  = items_sent;
      paused = 1'b0;
      while (items_sent - first < count) begin
         send_random_buffer();
         if (!paused && items_sent - first >= count / 2) begin
            wait_idle();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: a one byte pattern of zero, cut four bytes after the match.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h08, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h40, 1'b1);

      // Three byte pattern with overlap; the history matches right after a buffer
      // boundary but the new buffer is still too short, and the last byte matches.
      wait_idle();
      apply_setting(64'h0000_0000_0041_4241, 64'h0, 5'd3, 5'd0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b1);

      run_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 5'd16, PHASE_ITEMS);
      run_phase({$urandom, $urandom}, 64'h0, 5'd0, 5'd0, PHASE_ITEMS);
      run_phase(two_letter_word(), two_letter_word(), 5'd31, 5'd31, PHASE_ITEMS);
      run_phase(two_letter_word(), two_letter_word(), 5'd17, 5'd5, PHASE_ITEMS);
      run_phase(two_letter_word(), {$urandom, $urandom}, 5'd2, 5'd1, PHASE_ITEMS);
      repeat (4) begin
         run_phase({$urandom, $urandom}, {$urandom, $urandom},
                   5'($urandom_range(1, 16)), 5'($urandom_range(0, 31)), PHASE_ITEMS);
      end

      wait_idle();
      $display("Sent %0d bytes under %0d register settings, with out-of-range lengths",
               items_sent, settings_run);
      $display("and overlapping matches; %0d split items compared.", splits_checked);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/psf_pkg.sv
hw/rtl/psf_hist.sv
hw/rtl/psf_match.sv
hw/rtl/psf_rsp.sv
hw/rtl/pattern_split_point_finder.sv
hw/rtl/psf_checker.sv
dv/pattern_split_point_finder_checker.sv
dv/pattern_split_point_finder_tb.sv
